// ===== rtl/bfas_pkg.sv =====
`timescale 1ns / 1ps

package bfas_pkg;

   // default and limit of the field length
   localparam int MAX_FIELD_BITS_DEF = 64;

   // fixed widths
   localparam int WORD_W = 64;
   localparam int OFF_W  = 32;
   localparam int POS_W  = OFF_W + 1;
   localparam int CNT_W  = 7;
   localparam int FLG_W  = 7;

   // function codes of an input beat
   localparam logic [1:0] FN_READ  = 2'd0;
   localparam logic [1:0] FN_WRITE = 2'd1;
   localparam logic [1:0] FN_DATA  = 2'd2;

   // result kinds
   localparam logic [1:0] K_BUS_READ  = 2'd0;
   localparam logic [1:0] K_BUS_WRITE = 2'd1;
   localparam logic [1:0] K_VALUE     = 2'd2;
   localparam logic [1:0] K_ERROR     = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_ACC_TYPE   = 2'd1;
   localparam logic [1:0] ERR_RULE       = 2'd2;
   localparam logic [1:0] ERR_UNEXPECTED = 2'd3;

   // update rules
   localparam logic [1:0] RULE_PRESERVE = 2'd0;
   localparam logic [1:0] RULE_ONES     = 2'd1;
   localparam logic [1:0] RULE_ZEROS    = 2'd2;
   localparam logic [1:0] RULE_RESERVED = 2'd3;

   // access type codes
   localparam logic [3:0] ACC_ANY    = 4'd0;
   localparam logic [3:0] ACC_BYTE   = 4'd1;
   localparam logic [3:0] ACC_WORD   = 4'd2;
   localparam logic [3:0] ACC_DWORD  = 4'd3;
   localparam logic [3:0] ACC_QWORD  = 4'd4;
   localparam logic [3:0] ACC_BUFFER = 4'd5;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ,
      PH_WRITE
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERROR,
      S_VALUE,
      S_READ,
      S_FILL,
      S_DATA
   } seq_state_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] sel;   // log2 of access bytes
   } acc_info_type;

   // one chunk as worked out by the shared unit
   typedef struct packed {
      logic [WORD_W-1:0] addr;
      logic [3:0]        bytes;
      logic [WORD_W-1:0] wdata;
      logic [WORD_W-1:0] piece;
      logic [CNT_W-1:0]  cnt;
      logic              last;
   } chunk_res_type;

   function automatic acc_info_type acc_decode(input logic [3:0] code);
      acc_info_type info;
      info.ok  = 1'b1;
      info.sel = 2'd0;
      case (code) inside
         ACC_ANY, ACC_BYTE, ACC_BUFFER: info.sel = 2'd0;
         ACC_WORD:                      info.sel = 2'd1;
         ACC_DWORD:                     info.sel = 2'd2;
         ACC_QWORD:                     info.sel = 2'd3;
         default:                       info.ok  = 1'b0;
      endcase
      return info;
   endfunction

   // ones in the low n bits, n up to the word width
   function automatic logic [WORD_W-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [WORD_W-1:0] m;
      if (n >= CNT_W'(WORD_W)) begin
         m = '1;
      end else begin
         m = (WORD_W'(1) << n) - WORD_W'(1);
      end
      return m;
   endfunction

endpackage

// ===== rtl/bfas_chunk_unit.sv =====
`timescale 1ns / 1ps

module bfas_chunk_unit
   import bfas_pkg::*;
#(
   parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
   input  logic [POS_W-1:0]                        pos,
   input  logic [$clog2(MAX_FIELD_BITS+1)-1:0]     done,
   input  logic [$clog2(MAX_FIELD_BITS+1)-1:0]     len,
   input  logic [1:0]                              acc_sel,
   input  logic [WORD_W-1:0]                       base,
   input  logic [WORD_W-1:0]                       merge_word,
   input  logic [WORD_W-1:0]                       value,
   input  logic [WORD_W-1:0]                       data,
   output chunk_res_type                           res
);

   logic [CNT_W-1:0]  acc_bits;
   logic [5:0]        aoff;
   logic [CNT_W-1:0]  span;
   logic [CNT_W-1:0]  rem;
   logic [CNT_W-1:0]  cnt;
   logic [POS_W-1:0]  aligned;
   logic [WORD_W-1:0] cnt_mask;
   logic [WORD_W-1:0] fld_mask;
   logic [WORD_W-1:0] new_bits;
   logic [CNT_W:0]    reach;

   // chunk position and size within the aligned word
   always_comb begin
      acc_bits = CNT_W'(8) << acc_sel;
      aoff     = pos[5:0] & 6'(acc_bits - CNT_W'(1));
      span     = acc_bits - CNT_W'(aoff);
      rem      = CNT_W'(len - done);
      cnt      = (span < rem) ? span : rem;
      aligned  = pos & ~(POS_W'(acc_bits) - POS_W'(1));
      reach    = (CNT_W+1)'(done) + (CNT_W+1)'(cnt);
   end

   // merge new field bits into a word, and pick field bits out of read data
   always_comb begin
      cnt_mask = low_mask(cnt);
      fld_mask = cnt_mask << aoff;
      new_bits = (value >> done) & cnt_mask;
      res.addr  = base + WORD_W'(aligned >> 3);
      res.bytes = 4'd1 << acc_sel;
      res.wdata = ((merge_word & ~fld_mask) | (new_bits << aoff)) & low_mask(acc_bits);
      res.piece = ((data >> aoff) & cnt_mask) << done;
      res.cnt   = cnt;
      res.last  = reach >= (CNT_W+1)'(len);
   end

endmodule

// ===== rtl/bit_field_access_splitter.sv =====
`timescale 1ns / 1ps
// An accepted input beat is registered into the sequencer state, which then loads its
// results into the response registers. Throughput: one result beat per cycle through
// the shared chunk unit unless rsp_ready stalls; a field read's returned read word first
// takes a gathering step with no result. req_ready is low until the last result loads.
// Reset: synchronous, active high; clears sequencer, phase, region base, rsp_valid.

module bit_field_access_splitter
   import bfas_pkg::*;
#(
   parameter int MAX_FIELD_BITS = MAX_FIELD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [OFF_W-1:0]  req_field_bit_offset,
   input  logic [6:0]        req_field_bit_length,
   input  logic [FLG_W-1:0]  req_access_flags,
   input  logic [WORD_W-1:0] req_write_value,
   input  logic [WORD_W-1:0] req_bus_read_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [WORD_W-1:0] rsp_bus_address,
   output logic [3:0]        rsp_bus_bytes,
   output logic [WORD_W-1:0] rsp_bus_write_data,
   output logic [WORD_W-1:0] rsp_field_value,
   output logic [1:0]        rsp_error_code,
   output logic              rsp_last
);

   localparam int LEN_W = $clog2(MAX_FIELD_BITS + 1);

   // control state
   seq_state_type     state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [WORD_W-1:0] base_ff, base_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // operation context
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  done_ff, done_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [FLG_W-1:0]  flags_ff, flags_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [WORD_W-1:0] gathered_ff, gathered_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic [1:0]        err_ff, err_in;

   // response payload
   logic [1:0]        kind_ff, kind_in;
   logic [WORD_W-1:0] addr_ff, addr_in;
   logic [3:0]        bytes_ff, bytes_in;
   logic [WORD_W-1:0] wdata_ff, wdata_in;
   logic [WORD_W-1:0] fval_ff, fval_in;
   logic [1:0]        ecode_ff, ecode_in;
   logic              last_ff, last_in;

   acc_info_type      req_acc;
   acc_info_type      cur_acc;
   logic [1:0]        req_rule;
   logic [1:0]        cur_rule;
   logic [LEN_W-1:0]  req_len;
   logic [WORD_W-1:0] merge_word;
   logic              out_free;
   logic              out_load;
   chunk_res_type     chunk;

   assign req_acc  = acc_decode(req_access_flags[3:0]);
   assign req_rule = req_access_flags[6:5];
   assign cur_acc  = acc_decode(flags_ff[3:0]);
   assign cur_rule = flags_ff[6:5];
   assign req_len  = (req_field_bit_length > 7'(MAX_FIELD_BITS)) ?
                     LEN_W'(MAX_FIELD_BITS) : LEN_W'(req_field_bit_length);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // word that new bits go into: returned data or the fill pattern
   assign merge_word = (state_ff == S_DATA) ? data_ff :
                       ((cur_rule == RULE_ONES) ? '1 : '0);

   bfas_chunk_unit #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_chunk (
      .pos        (pos_ff),
      .done       (done_ff),
      .len        (len_ff),
      .acc_sel    (cur_acc.sel),
      .base       (base_ff),
      .merge_word (merge_word),
      .value      (value_ff),
      .data       (data_ff),
      .res        (chunk)
   );

   // sequencer register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // context and response payload
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      done_ff     <= done_in;
      len_ff      <= len_in;
      flags_ff    <= flags_in;
      value_ff    <= value_in;
      gathered_ff <= gathered_in;
      data_ff     <= data_in;
      err_ff      <= err_in;
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      bytes_ff    <= bytes_in;
      wdata_ff    <= wdata_in;
      fval_ff     <= fval_in;
      ecode_ff    <= ecode_in;
      last_ff     <= last_in;
   end

   // next state and outputs
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      base_in     = csr_wr_en ? csr_wr_data : base_ff;
      pos_in      = pos_ff;
      done_in     = done_ff;
      len_in      = len_ff;
      flags_in    = flags_ff;
      value_in    = value_ff;
      gathered_in = gathered_ff;
      data_in     = data_ff;
      err_in      = err_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      bytes_in    = bytes_ff;
      wdata_in    = wdata_ff;
      fval_in     = fval_ff;
      ecode_in    = ecode_ff;
      last_in     = last_ff;
      req_ready   = 1'b0;
      out_load    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_func)
                  FN_READ, FN_WRITE: begin
                     if (phase_ff != PH_IDLE) begin
                        err_in   = ERR_UNEXPECTED;
                        state_in = S_ERROR;
                     end else if (!req_acc.ok) begin
                        err_in   = ERR_ACC_TYPE;
                        state_in = S_ERROR;
                     end else if (req_rule == RULE_RESERVED) begin
                        err_in   = ERR_RULE;
                        state_in = S_ERROR;
                     end else begin
                        pos_in      = POS_W'(req_field_bit_offset);
                        done_in     = '0;
                        len_in      = req_len;
                        flags_in    = req_access_flags;
                        value_in    = req_write_value;
                        gathered_in = '0;
                        if (req_len == '0) begin
                           // empty field: read gives zero, write gives nothing
                           if (req_func == FN_READ) begin
                              state_in = S_VALUE;
                           end
                        end else if (req_func == FN_READ) begin
                           phase_in = PH_READ;
                           state_in = S_READ;
                        end else if (req_rule == RULE_PRESERVE) begin
                           phase_in = PH_WRITE;
                           state_in = S_READ;
                        end else begin
                           state_in = S_FILL;
                        end
                     end
                  end
                  FN_DATA: begin
                     if (phase_ff != PH_IDLE) begin
                        data_in  = req_bus_read_data;
                        state_in = S_DATA;
                     end else begin
                        err_in   = ERR_UNEXPECTED;
                        state_in = S_ERROR;
                     end
                  end
                  default: begin
                     err_in   = ERR_UNEXPECTED;
                     state_in = S_ERROR;
                  end
               endcase
            end
         end

         S_ERROR: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = K_ERROR;
               addr_in  = '0;
               bytes_in = '0;
               wdata_in = '0;
               fval_in  = '0;
               ecode_in = err_ff;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_VALUE: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = K_VALUE;
               addr_in  = '0;
               bytes_in = '0;
               wdata_in = '0;
               fval_in  = gathered_ff;
               ecode_in = ERR_NONE;
               last_in  = 1'b1;
               phase_in = PH_IDLE;
               state_in = S_IDLE;
            end
         end

         S_READ: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = K_BUS_READ;
               addr_in  = chunk.addr;
               bytes_in = chunk.bytes;
               wdata_in = '0;
               fval_in  = '0;
               ecode_in = ERR_NONE;
               last_in  = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_FILL: begin
            if (out_free) begin
               out_load = 1'b1;
               kind_in  = K_BUS_WRITE;
               addr_in  = chunk.addr;
               bytes_in = chunk.bytes;
               wdata_in = chunk.wdata;
               fval_in  = '0;
               ecode_in = ERR_NONE;
               last_in  = chunk.last;
               pos_in   = pos_ff + POS_W'(chunk.cnt);
               done_in  = done_ff + LEN_W'(chunk.cnt);
               if (chunk.last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_DATA: begin
            if (phase_ff == PH_READ) begin
               // gather the chunk, no result this cycle
               gathered_in = gathered_ff | chunk.piece;
               pos_in      = pos_ff + POS_W'(chunk.cnt);
               done_in     = done_ff + LEN_W'(chunk.cnt);
               state_in    = chunk.last ? S_VALUE : S_READ;
            end else if (out_free) begin
               out_load = 1'b1;
               kind_in  = K_BUS_WRITE;
               addr_in  = chunk.addr;
               bytes_in = chunk.bytes;
               wdata_in = chunk.wdata;
               fval_in  = '0;
               ecode_in = ERR_NONE;
               last_in  = chunk.last;
               pos_in   = pos_ff + POS_W'(chunk.cnt);
               done_in  = done_ff + LEN_W'(chunk.cnt);
               if (chunk.last) begin
                  phase_in = PH_IDLE;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_bus_address    = addr_ff;
   assign rsp_bus_bytes      = bytes_ff;
   assign rsp_bus_write_data = wdata_ff;
   assign rsp_field_value    = fval_ff;
   assign rsp_error_code     = ecode_ff;
   assign rsp_last           = last_ff;

   // a pending operation always has bits left to move
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && phase_ff != PH_IDLE) |-> (done_ff < len_ff))
      else $error("pending operation with no bits left");

   // fill writes never run while a bus read is outstanding
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL) |-> (phase_ff == PH_IDLE))
      else $error("fill write during outstanding read");

   // bus beats carry a power of two size, other beats carry none
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == K_BUS_READ || kind_ff == K_BUS_WRITE))
      |-> $onehot(bytes_ff))
      else $error("bus beat with bad size");

   // an error beat always carries a nonzero code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == K_ERROR) |-> (ecode_ff != ERR_NONE && last_ff))
      else $error("error beat without code");

   // a response slot is never overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(kind_ff) && $stable(addr_ff))
      else $error("stalled response overwritten");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bfas_pkg::*;

   // function code with no meaning to the block
   localparam logic [1:0] FN_UNUSED = 2'd3;
   // lowest and highest reserved access type
   localparam logic [3:0] ACC_BAD_LO = 4'd6;
   localparam logic [3:0] ACC_BAD_HI = 4'd15;
   localparam int RANDOM_BEATS = 400;
   localparam int RANDOM_PHASES = 5;

   typedef struct {
      logic [1:0]        kind;
      logic [WORD_W-1:0] addr;
      logic [3:0]        bytes;
      logic [WORD_W-1:0] wdata;
      logic [WORD_W-1:0] value;
      logic [1:0]        err;
      logic              last;
   } bus_result_type;

   // field splitter prediction and in-order result checking
   class field_access_scoreboard;
      phase_type         phase;
      logic [WORD_W-1:0] region_base;
      logic [OFF_W-1:0]  f_offset;
      int unsigned       f_length;
      logic [FLG_W-1:0]  f_flags;
      logic [WORD_W-1:0] f_value;
      int unsigned       f_done;
      logic [WORD_W-1:0] f_gathered;
      int unsigned       bit_in_word;
      int unsigned       chunk_bits;
      logic [WORD_W-1:0] chunk_addr;
      bus_result_type    expected_q[$];
      int                mismatches;

      function new();
         phase       = PH_IDLE;
         region_base = '0;
         f_offset    = '0;
         f_length    = 0;
         f_flags     = '0;
         f_value     = '0;
         f_done      = 0;
         f_gathered  = '0;
         mismatches  = 0;
      endfunction

      function void set_base(logic [WORD_W-1:0] base);
         region_base = base;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      // access width in bits, zero for a reserved type
      function int unsigned access_width(logic [3:0] code);
         case (code)
            ACC_ANY, ACC_BYTE, ACC_BUFFER: return 8;
            ACC_WORD:  return 16;
            ACC_DWORD: return 32;
            ACC_QWORD: return 64;
            default:   return 0;
         endcase
      endfunction

      function logic [WORD_W-1:0] ones_below(int unsigned n);
         if (n >= WORD_W) return '1;
         return (WORD_W'(1) << n) - WORD_W'(1);
      endfunction

      // next aligned access from the current bit, clamped to what is left
      function void next_chunk(int unsigned wbits);
         logic [POS_W-1:0] pos;
         pos = {1'b0, f_offset} + POS_W'(f_done);
         bit_in_word = pos[5:0] & 6'(wbits - 1);
         chunk_bits = wbits - bit_in_word;
         if (chunk_bits > f_length - f_done) chunk_bits = f_length - f_done;
         chunk_addr = region_base + ((WORD_W'(pos) & ~WORD_W'(wbits - 1)) >> 3);
      endfunction

      // new field bits over a base word, cut to the access width
      function logic [WORD_W-1:0] merged_word(logic [WORD_W-1:0] base_word,
                                              int unsigned wbits);
         logic [WORD_W-1:0] m;
         logic [WORD_W-1:0] bits;
         m = ones_below(chunk_bits) << bit_in_word;
         bits = (f_value >> f_done) & ones_below(chunk_bits);
         return ((base_word & ~m) | (bits << bit_in_word)) & ones_below(wbits);
      endfunction

      function void push(logic [1:0] kind, logic [WORD_W-1:0] addr, logic [3:0] bytes,
                         logic [WORD_W-1:0] wdata, logic [WORD_W-1:0] value,
                         logic [1:0] err, logic last);
         bus_result_type r;
         r.kind  = kind;
         r.addr  = addr;
         r.bytes = bytes;
         r.wdata = wdata;
         r.value = value;
         r.err   = err;
         r.last  = last;
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void push_error(logic [1:0] code);
         push(K_ERROR, '0, '0, '0, '0, code, 1'b1);
      endfunction

      // work out the results of one accepted input beat
      function void note_request(logic [1:0] fn, logic [OFF_W-1:0] off, logic [6:0] len,
                                 logic [FLG_W-1:0] flags, logic [WORD_W-1:0] wval,
                                 logic [WORD_W-1:0] rdata);
         int unsigned       wbits;
         logic [1:0]        rule;
         logic [WORD_W-1:0] fill;
         if (fn == FN_READ || fn == FN_WRITE) begin
            if (phase != PH_IDLE) begin
               push_error(ERR_UNEXPECTED);
               return;
            end
            wbits = access_width(flags[3:0]);
            rule = flags[6:5];
            if (wbits == 0) begin
               push_error(ERR_ACC_TYPE);
               return;
            end
            if (rule == RULE_RESERVED) begin
               push_error(ERR_RULE);
               return;
            end
            f_offset   = off;
            f_length   = (len > MAX_FIELD_BITS_DEF) ? MAX_FIELD_BITS_DEF : len;
            f_flags    = flags;
            f_value    = wval;
            f_done     = 0;
            f_gathered = '0;
            if (f_length == 0) begin
               if (fn == FN_READ) push(K_VALUE, '0, '0, '0, '0, ERR_NONE, 1'b1);
               return;
            end
            if (fn == FN_READ || rule == RULE_PRESERVE) begin
               next_chunk(wbits);
               push(K_BUS_READ, chunk_addr, 4'(wbits / 8), '0, '0, ERR_NONE, 1'b1);
               phase = (fn == FN_READ) ? PH_READ : PH_WRITE;
            end else begin
               fill = '0;
               if (rule == RULE_ONES) fill = '1;
               while (f_done < f_length) begin
                  next_chunk(wbits);
                  push(K_BUS_WRITE, chunk_addr, 4'(wbits / 8), merged_word(fill, wbits),
                       '0, ERR_NONE, f_done + chunk_bits >= f_length);
                  f_done += chunk_bits;
               end
            end
         end else if (fn == FN_DATA && phase != PH_IDLE) begin
            wbits = access_width(f_flags[3:0]);
            next_chunk(wbits);
            if (phase == PH_READ) begin
               f_gathered |= ((rdata >> bit_in_word) & ones_below(chunk_bits)) << f_done;
            end else begin
               push(K_BUS_WRITE, chunk_addr, 4'(wbits / 8), merged_word(rdata, wbits),
                    '0, ERR_NONE, f_done + chunk_bits >= f_length);
            end
            f_done += chunk_bits;
            if (f_done < f_length) begin
               next_chunk(wbits);
               push(K_BUS_READ, chunk_addr, 4'(wbits / 8), '0, '0, ERR_NONE, 1'b1);
            end else begin
               if (phase == PH_READ) push(K_VALUE, '0, '0, '0, f_gathered, ERR_NONE, 1'b1);
               phase = PH_IDLE;
            end
         end else begin
            push_error(ERR_UNEXPECTED);
         end
      endfunction

      // compare one result beat with the oldest expectation
      function void check_result(bus_result_type got);
         bus_result_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result beat with nothing expected: kind %0d addr %h",
                        $time, got.kind, got.addr);
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.addr !== want.addr || got.bytes !== want.bytes ||
             got.wdata !== want.wdata || got.value !== want.value ||
             got.err !== want.err || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: result beat mismatch", $time);
               $display("  expected kind %0d addr %h bytes %0d wdata %h value %h err %0d last %b",
                        want.kind, want.addr, want.bytes, want.wdata, want.value, want.err,
                        want.last);
               $display("  actual   kind %0d addr %h bytes %0d wdata %h value %h err %0d last %b",
                        got.kind, got.addr, got.bytes, got.wdata, got.value, got.err,
                        got.last);
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [WORD_W-1:0] csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func = FN_READ;
   logic [OFF_W-1:0]  req_field_bit_offset = '0;
   logic [6:0]        req_field_bit_length = '0;
   logic [FLG_W-1:0]  req_access_flags = '0;
   logic [WORD_W-1:0] req_write_value = '0;
   logic [WORD_W-1:0] req_bus_read_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_kind;
   logic [WORD_W-1:0] rsp_bus_address;
   logic [3:0]        rsp_bus_bytes;
   logic [WORD_W-1:0] rsp_bus_write_data;
   logic [WORD_W-1:0] rsp_field_value;
   logic [1:0]        rsp_error_code;
   logic              rsp_last;

   bit          idle_on = 1'b1;
   int unsigned stall_left = 0;
   int          beats_sent = 0;
   field_access_scoreboard sb = new();

   bit_field_access_splitter DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_field_bit_offset(req_field_bit_offset),
      .req_field_bit_length(req_field_bit_length),
      .req_access_flags    (req_access_flags),
      .req_write_value     (req_write_value),
      .req_bus_read_data   (req_bus_read_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_bus_address     (rsp_bus_address),
      .rsp_bus_bytes       (rsp_bus_bytes),
      .rsp_bus_write_data  (rsp_bus_write_data),
      .rsp_field_value     (rsp_field_value),
      .rsp_error_code      (rsp_error_code),
      .rsp_last            (rsp_last)
   );

   always #5 clock = ~clock;

   // result side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check every result beat taken
   always @(posedge clock) begin : result_monitor
      bus_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got.kind  = rsp_kind;
         got.addr  = rsp_bus_address;
         got.bytes = rsp_bus_bytes;
         got.wdata = rsp_bus_write_data;
         got.value = rsp_field_value;
         got.err   = rsp_error_code;
         got.last  = rsp_last;
         sb.check_result(got);
      end
   end

   function automatic logic [WORD_W-1:0] any_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [OFF_W-1:0] pick_offset();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 255);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [6:0] pick_length();
      case ($urandom_range(0, 19))
         0:             return 7'd0;
         1:             return 7'($urandom_range(65, 127));
         2:             return 7'd64;
         3, 4, 5, 6, 7: return 7'($urandom_range(1, 8));
         default:       return 7'($urandom_range(1, 64));
      endcase
   endfunction

   // mostly legal flags, now and then a reserved type or rule
   function automatic logic [FLG_W-1:0] pick_flags();
      logic [3:0] acc;
      logic [1:0] rule;
      acc = 4'($urandom_range(ACC_ANY, ACC_BUFFER));
      if ($urandom_range(0, 11) == 0) acc = 4'($urandom_range(ACC_BAD_LO, ACC_BAD_HI));
      rule = 2'($urandom_range(RULE_PRESERVE, RULE_ZEROS));
      if ($urandom_range(0, 11) == 0) rule = RULE_RESERVED;
      return {rule, 1'($urandom_range(0, 1)), acc};
   endfunction

   // present one beat, optionally after an idle burst, and wait until taken
   task automatic send_beat(input logic [1:0] fn, input logic [OFF_W-1:0] off,
                            input logic [6:0] len, input logic [FLG_W-1:0] flags,
                            input logic [WORD_W-1:0] wval, input logic [WORD_W-1:0] rdata);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_func             <= fn;
      req_field_bit_offset <= off;
      req_field_bit_length <= len;
      req_access_flags     <= flags;
      req_write_value      <= wval;
      req_bus_read_data    <= rdata;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(fn, off, len, flags, wval, rdata);
      beats_sent++;
   endtask

   // return bus data until the pending field operation is done
   task automatic finish_op(input bit noisy);
      while (sb.busy()) begin
         if (noisy && $urandom_range(0, 15) == 0)
            send_beat($urandom_range(0, 1) ? FN_WRITE : FN_READ, pick_offset(),
                      pick_length(), pick_flags(), any_word(), any_word());
         else
            send_beat(FN_DATA, pick_offset(), pick_length(), pick_flags(), any_word(),
                      any_word());
      end
   endtask

   // region base is written only with the block idle
   task automatic set_region_base(input logic [WORD_W-1:0] base);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // an empty field write has no result and leaves the block idle
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_base(base);
   endtask

   initial begin : stimulus
      logic [WORD_W-1:0] bases[RANDOM_PHASES];
      int unsigned       r;
      int                goal;
      bases[0] = '0;
      bases[1] = {$urandom, $urandom};
      bases[2] = 64'h8000_0000_0000_0000;
      bases[3] = {$urandom, $urandom};
      bases[4] = 64'hFFFF_FFFF_FFFF_FF00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part, base at the top so addresses wrap
      set_region_base('1);
      // single bit through a byte access
      send_beat(FN_READ, '0, 7'd1, {RULE_PRESERVE, 1'b0, ACC_BYTE}, '0, '1);
      finish_op(1'b0);
      // full width field at the last offset, three dword pieces
      send_beat(FN_READ, '1, 7'd64, {RULE_PRESERVE, 1'b1, ACC_DWORD}, '1, '0);
      finish_op(1'b0);
      // over-long field is cut to the maximum
      send_beat(FN_READ, 32'd8, 7'd127, {RULE_ZEROS, 1'b0, ACC_QWORD}, any_word(), '1);
      finish_op(1'b0);
      // read-modify-write over two words
      send_beat(FN_WRITE, 32'd5, 7'd20, {RULE_PRESERVE, 1'b0, ACC_WORD}, '1, '0);
      finish_op(1'b0);
      // fill writes: nine bytes, a qword across the offset top, a buffer byte
      send_beat(FN_WRITE, 32'd3, 7'd64, {RULE_ONES, 1'b0, ACC_ANY},
                64'h0123_4567_89AB_CDEF, '0);
      send_beat(FN_WRITE, 32'hFFFF_FFFC, 7'd10, {RULE_ZEROS, 1'b1, ACC_QWORD}, '1, '1);
      send_beat(FN_WRITE, '0, 7'd8, {RULE_ONES, 1'b0, ACC_BUFFER}, '0, '0);
      // bad access type, bad rule on a read, both bad at once
      send_beat(FN_READ, '0, 7'd8, {RULE_ONES, 1'b0, ACC_BAD_HI}, '0, '0);
      send_beat(FN_READ, '0, 7'd8, {RULE_RESERVED, 1'b0, ACC_WORD}, '0, '0);
      send_beat(FN_WRITE, '0, 7'd8, {RULE_RESERVED, 1'b1, ACC_BAD_LO}, '1, '0);
      // empty fields
      send_beat(FN_READ, 32'd17, 7'd0, {RULE_PRESERVE, 1'b0, ACC_DWORD}, '0, '0);
      send_beat(FN_WRITE, 32'd17, 7'd0, {RULE_ONES, 1'b0, ACC_DWORD}, '1, '0);
      // request while a read waits for its data
      send_beat(FN_READ, 32'd12, 7'd16, {RULE_PRESERVE, 1'b0, ACC_BYTE}, '0, '0);
      send_beat(FN_WRITE, '0, 7'd4, {RULE_ONES, 1'b0, ACC_BYTE}, '1, '0);
      finish_op(1'b0);
      // bus data with nothing outstanding, unused function code
      send_beat(FN_DATA, '0, 7'd1, '0, '0, '1);
      send_beat(FN_UNUSED, '1, '1, '1, '1, '1);

      // random part, one region base per phase, phase 2 and the last phase without idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_region_base(bases[p]);
         idle_on = (p != 2 && p != RANDOM_PHASES - 1);
         goal = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
         while (beats_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_beat(FN_DATA, pick_offset(), pick_length(), pick_flags(), any_word(),
                         any_word());
            end else if (r < 7) begin
               send_beat(FN_UNUSED, pick_offset(), pick_length(), pick_flags(), any_word(),
                         any_word());
            end else begin
               send_beat($urandom_range(0, 1) ? FN_WRITE : FN_READ, pick_offset(),
                         pick_length(), pick_flags(), any_word(), any_word());
               finish_op(1'b1);
            end
         end
      end

      // drain and let the block settle
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== bit_field_access_splitter.f =====
rtl/bfas_pkg.sv
rtl/bfas_chunk_unit.sv
rtl/bit_field_access_splitter.sv
sim/tb.sv
